// ===== rtl/hsvd_pkg.sv =====
`default_nettype none
package hsvd_pkg;

  localparam int HUE_W   = 9;
  localparam int COMP_W  = 8;
  localparam int SHIFT_W = 4;
  localparam int REM_W   = 6;
  localparam int PROD_W  = 14;

  localparam logic [HUE_W-1:0]   HUE_WRAP   = 9'd360;
  localparam logic [HUE_W-1:0]   SECTOR_DEG = 9'd60;
  localparam logic [REM_W-1:0]   REM_SPAN   = 6'd60;
  localparam logic [COMP_W-1:0]  COMP_MAX   = 8'hFF;
  localparam logic [SHIFT_W-1:0] SHIFT_LIM  = 4'd8;

  // floor(p/60) == (p * 17477) >> 20 for every p below 23831
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;
  localparam logic [RECIP_W-1:0] RECIP_60 = 15'd17477;
  localparam int QPROD_W = PROD_W + RECIP_W;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t            sector;
    logic [REM_W-1:0]   rem;
    logic [COMP_W-1:0]  val;
    logic [COMP_W-1:0]  inv_sat;
  } front_t;

  typedef struct packed {
    sector_t            sector;
    logic               gray;
    logic [COMP_W-1:0]  val;
    logic [COMP_W-1:0]  base;
    logic [COMP_W-1:0]  up_q;
    logic [COMP_W-1:0]  down_q;
  } interp_t;

  localparam logic [COMP_W-1:0] DIM_ROM [256] = '{
    8'd0, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5,
    8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
    8'd7, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd9,
    8'd9, 8'd9, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd11, 8'd11,
    8'd12, 8'd12, 8'd12, 8'd12, 8'd12, 8'd13, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd14,
    8'd14, 8'd15, 8'd15, 8'd15, 8'd16, 8'd16, 8'd16, 8'd16, 8'd17, 8'd17, 8'd17, 8'd18,
    8'd18, 8'd18, 8'd19, 8'd19, 8'd19, 8'd20, 8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd22,
    8'd22, 8'd23, 8'd23, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd26, 8'd26, 8'd27, 8'd27,
    8'd28, 8'd28, 8'd29, 8'd29, 8'd30, 8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd33, 8'd34,
    8'd35, 8'd35, 8'd36, 8'd36, 8'd37, 8'd38, 8'd38, 8'd39, 8'd40, 8'd40, 8'd41, 8'd42,
    8'd43, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52,
    8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64,
    8'd65, 8'd66, 8'd68, 8'd69, 8'd70, 8'd71, 8'd73, 8'd74, 8'd75, 8'd76, 8'd78, 8'd79,
    8'd81, 8'd82, 8'd83, 8'd85, 8'd86, 8'd88, 8'd90, 8'd91, 8'd93, 8'd94, 8'd96, 8'd98,
    8'd99, 8'd101, 8'd103, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114, 8'd116,
    8'd118, 8'd121, 8'd123, 8'd125, 8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139,
    8'd141, 8'd144, 8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
    8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190, 8'd193, 8'd196,
    8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218, 8'd222, 8'd226, 8'd230, 8'd234,
    8'd238, 8'd242, 8'd248, 8'd255
  };

endpackage
`default_nettype wire

// ===== rtl/hsvd_if.sv =====
`default_nettype none
interface hsv_pix_if;
  logic                        valid;
  logic                        ready;
  logic [hsvd_pkg::HUE_W-1:0]  hue;
  logic [hsvd_pkg::COMP_W-1:0] saturation;
  logic [hsvd_pkg::COMP_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface rgb_pix_if;
  logic                        valid;
  logic                        ready;
  logic [hsvd_pkg::COMP_W-1:0] red;
  logic [hsvd_pkg::COMP_W-1:0] green;
  logic [hsvd_pkg::COMP_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== rtl/hsvd_front.sv =====
`default_nettype none
// Stage 1: hue wrap, sector/remainder split, dimming lookups.
module hsvd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  hsv_pix_if.sink           pix,
  output hsvd_pkg::front_t  dout,
  output logic              dout_valid,
  input  wire logic         dout_ready
);

  logic                       v_r;
  hsvd_pkg::front_t           d_r;
  hsvd_pkg::front_t           d_nxt;
  logic                       stage_rdy;
  logic [hsvd_pkg::HUE_W-1:0] hue_w;
  logic [hsvd_pkg::HUE_W-1:0] rem_w;

  assign stage_rdy = !v_r || dout_ready;
  assign pix.ready = stage_rdy;

  always_comb begin
    hue_w = (pix.hue >= hsvd_pkg::HUE_WRAP) ? pix.hue - hsvd_pkg::HUE_WRAP : pix.hue;
    if (hue_w < hsvd_pkg::SECTOR_DEG) begin
      d_nxt.sector = hsvd_pkg::SEC_RY;
      rem_w        = hue_w;
    end else if (hue_w < 9'(2 * hsvd_pkg::SECTOR_DEG)) begin
      d_nxt.sector = hsvd_pkg::SEC_YG;
      rem_w        = hue_w - 9'(hsvd_pkg::SECTOR_DEG);
    end else if (hue_w < 9'(3 * hsvd_pkg::SECTOR_DEG)) begin
      d_nxt.sector = hsvd_pkg::SEC_GC;
      rem_w        = hue_w - 9'(2 * hsvd_pkg::SECTOR_DEG);
    end else if (hue_w < 9'(4 * hsvd_pkg::SECTOR_DEG)) begin
      d_nxt.sector = hsvd_pkg::SEC_CB;
      rem_w        = hue_w - 9'(3 * hsvd_pkg::SECTOR_DEG);
    end else if (hue_w < 9'(5 * hsvd_pkg::SECTOR_DEG)) begin
      d_nxt.sector = hsvd_pkg::SEC_BM;
      rem_w        = hue_w - 9'(4 * hsvd_pkg::SECTOR_DEG);
    end else begin
      d_nxt.sector = hsvd_pkg::SEC_MR;
      rem_w        = hue_w - 9'(5 * hsvd_pkg::SECTOR_DEG);
    end
    d_nxt.rem     = rem_w[hsvd_pkg::REM_W-1:0];
    d_nxt.val     = hsvd_pkg::DIM_ROM[pix.brightness];
    // dimmed inverse saturation; 255 here means gray
    d_nxt.inv_sat = hsvd_pkg::DIM_ROM[hsvd_pkg::COMP_MAX - pix.saturation];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (stage_rdy) begin
      v_r <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy && pix.valid) begin
      d_r <= d_nxt;
    end
  end

  assign dout       = d_r;
  assign dout_valid = v_r;

endmodule
`default_nettype wire

// ===== rtl/hsvd_interp.sv =====
`default_nettype none
// Stages 2..4: base level, span products, divide by 60 via reciprocal.
module hsvd_interp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hsvd_pkg::front_t din,
  input  wire logic          din_valid,
  output logic               din_ready,
  output hsvd_pkg::interp_t  dout,
  output logic               dout_valid,
  input  wire logic          dout_ready
);

  typedef struct packed {
    hsvd_pkg::sector_t             sector;
    logic                          gray;
    logic [hsvd_pkg::REM_W-1:0]    rem;
    logic [hsvd_pkg::COMP_W-1:0]   val;
    logic [hsvd_pkg::COMP_W-1:0]   base;
  } base_t;

  typedef struct packed {
    hsvd_pkg::sector_t             sector;
    logic                          gray;
    logic [hsvd_pkg::COMP_W-1:0]   val;
    logic [hsvd_pkg::COMP_W-1:0]   base;
    logic [hsvd_pkg::PROD_W-1:0]   up_p;
    logic [hsvd_pkg::PROD_W-1:0]   down_p;
  } prod_t;

  logic              v2_r, v3_r, v4_r;
  logic              rdy2, rdy3, rdy4;
  base_t             s2_r, s2_nxt;
  prod_t             s3_r, s3_nxt;
  hsvd_pkg::interp_t s4_r, s4_nxt;

  logic [2*hsvd_pkg::COMP_W-1:0] base_prod;
  logic [hsvd_pkg::COMP_W-1:0]   span;
  logic [hsvd_pkg::QPROD_W-1:0]  up_qp;
  logic [hsvd_pkg::QPROD_W-1:0]  down_qp;

  assign rdy4      = !v4_r || dout_ready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign din_ready = rdy2;

  // stage 2: base = (inv_sat * val) >> 8, where inv_sat is the ROM output for 255 - sat
  always_comb begin
    base_prod     = 16'(din.inv_sat) * 16'(din.val);
    s2_nxt.sector = din.sector;
    s2_nxt.gray   = (din.inv_sat == hsvd_pkg::COMP_MAX);
    s2_nxt.rem    = din.rem;
    s2_nxt.val    = din.val;
    s2_nxt.base   = base_prod[2*hsvd_pkg::COMP_W-1:hsvd_pkg::COMP_W];
  end

  // stage 3: span times remainder and its complement
  always_comb begin
    span          = s2_r.val - s2_r.base;
    s3_nxt.sector = s2_r.sector;
    s3_nxt.gray   = s2_r.gray;
    s3_nxt.val    = s2_r.val;
    s3_nxt.base   = s2_r.base;
    s3_nxt.up_p   = 14'(span) * 14'(s2_r.rem);
    s3_nxt.down_p = 14'(span) * 14'(hsvd_pkg::REM_SPAN - s2_r.rem);
  end

  // stage 4: quotient by 60
  always_comb begin
    up_qp         = 29'(s3_r.up_p) * 29'(hsvd_pkg::RECIP_60);
    down_qp       = 29'(s3_r.down_p) * 29'(hsvd_pkg::RECIP_60);
    s4_nxt.sector = s3_r.sector;
    s4_nxt.gray   = s3_r.gray;
    s4_nxt.val    = s3_r.val;
    s4_nxt.base   = s3_r.base;
    s4_nxt.up_q   = up_qp[hsvd_pkg::RECIP_SHIFT+hsvd_pkg::COMP_W-1:hsvd_pkg::RECIP_SHIFT];
    s4_nxt.down_q = down_qp[hsvd_pkg::RECIP_SHIFT+hsvd_pkg::COMP_W-1:hsvd_pkg::RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= din_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && din_valid) s2_r <= s2_nxt;
    if (rdy3 && v2_r)      s3_r <= s3_nxt;
    if (rdy4 && v3_r)      s4_r <= s4_nxt;
  end

  assign dout       = s4_r;
  assign dout_valid = v4_r;

endmodule
`default_nettype wire

// ===== rtl/hsvd_out.sv =====
`default_nettype none
// Stage 5: sector select, attenuation, output register.
module hsvd_out (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hsvd_pkg::interp_t             din,
  input  wire logic                          din_valid,
  output logic                               din_ready,
  input  wire logic [hsvd_pkg::SHIFT_W-1:0]  atten,
  rgb_pix_if.source                          pix
);

  logic                        v_r;
  logic                        stage_rdy;
  logic [hsvd_pkg::COMP_W-1:0] up, down;
  logic [hsvd_pkg::COMP_W-1:0] r_sel, g_sel, b_sel;
  logic [hsvd_pkg::COMP_W-1:0] red_r, green_r, blue_r;
  logic [hsvd_pkg::COMP_W-1:0] red_nxt, green_nxt, blue_nxt;

  function automatic logic [hsvd_pkg::COMP_W-1:0] attenuate(
    input logic [hsvd_pkg::COMP_W-1:0]  c,
    input logic [hsvd_pkg::SHIFT_W-1:0] sh
  );
    logic [hsvd_pkg::COMP_W-1:0] res;
    if (sh >= hsvd_pkg::SHIFT_LIM) begin
      res = '0;
    end else begin
      res = c >> sh;
    end
    return res;
  endfunction

  assign stage_rdy = !v_r || pix.ready;
  assign din_ready = stage_rdy;

  always_comb begin
    up   = din.up_q + din.base;
    down = din.down_q + din.base;
    if (din.gray) begin
      r_sel = din.val;
      g_sel = din.val;
      b_sel = din.val;
    end else begin
      case (din.sector)
        hsvd_pkg::SEC_RY: begin r_sel = din.val;  g_sel = up;       b_sel = din.base; end
        hsvd_pkg::SEC_YG: begin r_sel = down;     g_sel = din.val;  b_sel = din.base; end
        hsvd_pkg::SEC_GC: begin r_sel = din.base; g_sel = din.val;  b_sel = up;       end
        hsvd_pkg::SEC_CB: begin r_sel = din.base; g_sel = down;     b_sel = din.val;  end
        hsvd_pkg::SEC_BM: begin r_sel = up;       g_sel = din.base; b_sel = din.val;  end
        default:          begin r_sel = din.val;  g_sel = din.base; b_sel = down;     end
      endcase
    end
    red_nxt   = attenuate(r_sel, atten);
    green_nxt = attenuate(g_sel, atten);
    blue_nxt  = attenuate(b_sel, atten);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (stage_rdy) begin
      v_r <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy && din_valid) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign pix.valid = v_r;
  assign pix.red   = red_r;
  assign pix.green = green_r;
  assign pix.blue  = blue_r;

endmodule
`default_nettype wire

// ===== rtl/hsv_to_rgb_dimmed_unit.sv =====
// Channel   Dir   Handshake        Payload
// in_pix    in    valid/ready      hue[8:0], saturation[7:0], brightness[7:0]
// out_pix   out   valid/ready      red[7:0], green[7:0], blue[7:0]
// cfg       in    cfg_we           cfg_wdata[3:0] = attenuation shift
//
// Five register stages: dimming lookup, base multiply, span multiplies,
// reciprocal divide by 60, select and attenuate. One pixel per cycle while
// out_pix.ready holds. Synchronous active-low reset clears all stage valids
// and the shift register (0). A stall holds the stalled stage; bubbles ahead
// of it still fill, so in_pix.ready drops only when all five stages are full.
`default_nettype none
module hsv_to_rgb_dimmed_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  hsv_pix_if.sink                            in_pix,
  rgb_pix_if.source                          out_pix,
  input  wire logic                          cfg_we,
  input  wire logic [hsvd_pkg::SHIFT_W-1:0]  cfg_wdata
);

  logic [hsvd_pkg::SHIFT_W-1:0] atten_r;
  hsvd_pkg::front_t             front_d;
  logic                         front_v, front_rdy;
  hsvd_pkg::interp_t            interp_d;
  logic                         interp_v, interp_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atten_r <= '0;
    end else if (cfg_we) begin
      atten_r <= cfg_wdata;
    end
  end

  hsvd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (in_pix),
    .dout       (front_d),
    .dout_valid (front_v),
    .dout_ready (front_rdy)
  );

  hsvd_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .din        (front_d),
    .din_valid  (front_v),
    .din_ready  (front_rdy),
    .dout       (interp_d),
    .dout_valid (interp_v),
    .dout_ready (interp_rdy)
  );

  hsvd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .din       (interp_d),
    .din_valid (interp_v),
    .din_ready (interp_rdy),
    .atten     (atten_r),
    .pix       (out_pix)
  );

endmodule
`default_nettype wire

// ===== rtl/hsvd_checker.sv =====
`default_nettype none
module hsvd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [hsvd_pkg::COMP_W-1:0]   out_red,
  input wire logic [hsvd_pkg::COMP_W-1:0]   out_green,
  input wire logic [hsvd_pkg::COMP_W-1:0]   out_blue
);

  // pipeline only pushes back when full, so a result must be on offer
  a_bp_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a transfer at the output frees a slot all the way back
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("output transfer did not open the input");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed or dropped");

endmodule

bind hsv_to_rgb_dimmed_unit hsvd_checker u_hsvd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_red   (out_pix.red),
  .out_green (out_pix.green),
  .out_blue  (out_pix.blue)
);
`default_nettype wire
